/* rtl/decision_tree_predict_unit_macros.svh */
// Assertion macros shared by the checker of the decision tree predict unit.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef DECISION_TREE_PREDICT_UNIT_MACROS_SVH
`define DECISION_TREE_PREDICT_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define DTP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("decision tree predict unit: check failed");

// Next-cycle implication, held off while reset is high
`define DTP_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("decision tree predict unit: check failed");

`endif

/* rtl/dtp_pkg.sv */
// Shared types, codes and sizes of the decision tree predict unit.
// No dependencies; used by every module of the block.
`default_nettype none

package dtp_pkg;

   // Default sizes of the tables and the walk limit
   localparam int NODE_COUNT_DEF    = 256;
   localparam int FEATURE_COUNT_DEF = 64;
   localparam int MAX_DEPTH_DEF     = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Stream widths
   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   // Operation codes carried in req_tuser
   localparam logic [1:0] OP_WRITE_NODE    = 2'd0;
   localparam logic [1:0] OP_WRITE_FEATURE = 2'd1;
   localparam logic [1:0] OP_EVALUATE      = 2'd2;

   typedef enum logic [1:0] {
      KIND_NODE    = 2'd0,
      KIND_FEATURE = 2'd1,
      KIND_EVAL    = 2'd2
   } dtp_kind_type;

   // One decoded command
   typedef struct packed {
      dtp_kind_type kind;
      logic [7:0]   node_index;
      logic [7:0]   left_child;
      logic [7:0]   right_child;
      logic [5:0]   split_feature;
      logic [31:0]  split_value;
      logic         is_terminal;
      logic [31:0]  leaf_value;
      logic [5:0]   feature_index;
      logic [31:0]  feature_value;
      logic [7:0]   root_index;
      logic         accumulate;
   } dtp_entry_type;

   // Queue slot: push side and head side
   typedef struct packed {
      logic          valid;
      dtp_entry_type entry;
   } dtp_slot_type;

endpackage

`default_nettype wire

/* rtl/dtp_front.sv */
// Front end: unpacks request transfers, classifies them and drops the ones
// that have no effect. Depends on dtp_pkg; feeds dtp_queue.
`default_nettype none

module dtp_front #(
   parameter int NODE_COUNT    = dtp_pkg::NODE_COUNT_DEF,
   parameter int FEATURE_COUNT = dtp_pkg::FEATURE_COUNT_DEF
) (
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // node_index, left_child, right_child, split_feature, split_value,
   // is_terminal, leaf_value, feature_index, feature_value, root_index,
   // accumulate, zero fill
   input  wire logic [dtp_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [dtp_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire logic                          queue_full,
   output dtp_pkg::dtp_slot_type              push
);

   dtp_pkg::dtp_entry_type entry;
   logic                   keep;

   // Accept whenever the queue has room
   assign req_tready = !queue_full;

   // Unpack and classify
   always_comb begin
      entry.kind          = dtp_pkg::KIND_EVAL;
      entry.node_index    = req_tdata[7:0];
      entry.left_child    = req_tdata[15:8];
      entry.right_child   = req_tdata[23:16];
      entry.split_feature = req_tdata[29:24];
      entry.split_value   = req_tdata[61:30];
      entry.is_terminal   = req_tdata[62];
      entry.leaf_value    = req_tdata[94:63];
      entry.feature_index = req_tdata[100:95];
      entry.feature_value = req_tdata[132:101];
      entry.root_index    = req_tdata[140:133];
      entry.accumulate    = req_tdata[141];
      keep                = 1'b0;
      unique case (req_tuser)
         dtp_pkg::OP_WRITE_NODE: begin
            entry.kind = dtp_pkg::KIND_NODE;
            keep       = 32'(entry.node_index) < 32'(NODE_COUNT);
         end
         dtp_pkg::OP_WRITE_FEATURE: begin
            entry.kind = dtp_pkg::KIND_FEATURE;
            keep       = 32'(entry.feature_index) < 32'(FEATURE_COUNT);
         end
         dtp_pkg::OP_EVALUATE: begin
            entry.kind = dtp_pkg::KIND_EVAL;
            keep       = 1'b1;
         end
         default: begin
            // unused operation: swallowed
            keep = 1'b0;
         end
      endcase
   end

   assign push.valid = req_tvalid && req_tready && keep;
   assign push.entry = entry;

endmodule

`default_nettype wire

/* rtl/dtp_queue.sv */
// Short command queue that decouples the front end from the tree walker.
// Depends on dtp_pkg.
`default_nettype none

module dtp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  dtp_pkg::dtp_slot_type push,
   input  wire logic             pop,
   output logic                  full,
   output dtp_pkg::dtp_slot_type head
);

   localparam int AW = $clog2(dtp_pkg::QUEUE_DEPTH);

   dtp_pkg::dtp_entry_type slot_ff [dtp_pkg::QUEUE_DEPTH];
   logic [AW-1:0]          wr_ptr_ff;
   logic [AW-1:0]          rd_ptr_ff;
   logic [AW:0]            count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full       = count_ff == (AW+1)'(dtp_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + AW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + AW'(1);
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (AW+1)'(1);
            2'b01:   count_ff <= count_ff - (AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push.entry;
   end

endmodule

`default_nettype wire

/* rtl/dtp_walker.sv */
// Back end: node and feature tables, tree walk sequencer, running sum and
// result register. Depends on dtp_pkg; takes commands from dtp_queue.
`default_nettype none

module dtp_walker #(
   parameter int NODE_COUNT    = dtp_pkg::NODE_COUNT_DEF,
   parameter int FEATURE_COUNT = dtp_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_DEPTH     = dtp_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  dtp_pkg::dtp_slot_type              head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // prediction, leaf_reached
   output logic [dtp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // walk_error
   output logic [dtp_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   localparam logic [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
   localparam logic [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NODE,
      ST_FEAT
   } state_type;

   typedef struct packed {
      logic [31:0] mean;
      logic        term;
      logic [5:0]  feat;
      logic [31:0] thresh;
      logic [7:0]  right;
      logic [7:0]  left;
   } node_word_type;

   // Tables
   node_word_type      node_mem_ff [NODE_COUNT];
   logic [31:0]        feat_mem_ff [FEATURE_COUNT];
   node_word_type      node_rd_ff;
   logic [31:0]        feat_rd_ff;

   logic               node_we;
   logic [NODE_AW-1:0] node_wa;
   node_word_type      node_wd;
   logic               node_re;
   logic [NODE_AW-1:0] node_ra;
   logic               feat_we;
   logic [FEAT_AW-1:0] feat_wa;
   logic               feat_re;
   logic [FEAT_AW-1:0] feat_ra;

   // Sequencer state and result register
   state_type          state_ff,     state_in;
   logic [7:0]         node_ff,      node_in;
   logic [DEPTH_W-1:0] depth_ff,     depth_in;
   logic               acc_ff,       acc_in;
   logic [39:0]        sum_ff,       sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        pred_ff,      pred_in;
   logic [7:0]         leaf_ff,      leaf_in;
   logic               err_ff,       err_in;

   logic               out_free;
   logic [39:0]        leaf_sext;
   logic [40:0]        sum_wide;
   logic [39:0]        sum_sat;
   logic [7:0]         next_node;

   // Node table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (node_we) node_mem_ff[node_wa] <= node_wd;
      if (node_re) node_rd_ff <= node_mem_ff[node_ra];
   end

   // Feature table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (feat_we) feat_mem_ff[feat_wa] <= head.entry.feature_value;
      if (feat_re) feat_rd_ff <= feat_mem_ff[feat_ra];
   end

   // Leaf mean into the running sum, saturated to 40 bits
   assign leaf_sext = {{8{node_rd_ff.mean[31]}}, node_rd_ff.mean};
   assign sum_wide  = {sum_ff[39], sum_ff} + {leaf_sext[39], leaf_sext};
   assign sum_sat   = (sum_wide[40] != sum_wide[39]) ?
                      (sum_wide[40] ? SUM_MIN : SUM_MAX) : sum_wide[39:0];

   // Daughter chosen by the signed compare
   assign next_node = ($signed(feat_rd_ff) <= $signed(node_rd_ff.thresh)) ?
                      node_rd_ff.left : node_rd_ff.right;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Write data taken straight from the queue head
   assign node_wa = NODE_AW'(head.entry.node_index);
   assign feat_wa = FEAT_AW'(head.entry.feature_index);
   always_comb begin
      node_wd.mean   = head.entry.leaf_value;
      node_wd.term   = head.entry.is_terminal;
      node_wd.feat   = head.entry.split_feature;
      node_wd.thresh = head.entry.split_value;
      node_wd.right  = head.entry.right_child;
      node_wd.left   = head.entry.left_child;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pred_in      = pred_ff;
      leaf_in      = leaf_ff;
      err_in       = err_ff;
      pop          = 1'b0;
      node_we      = 1'b0;
      feat_we      = 1'b0;
      node_re      = 1'b0;
      node_ra      = NODE_AW'(head.entry.root_index);
      feat_re      = 1'b0;
      feat_ra      = FEAT_AW'(node_rd_ff.feat);
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.kind)
                  dtp_pkg::KIND_NODE: begin
                     node_we = 1'b1;
                     pop     = 1'b1;
                  end
                  dtp_pkg::KIND_FEATURE: begin
                     feat_we = 1'b1;
                     pop     = 1'b1;
                  end
                  dtp_pkg::KIND_EVAL: begin
                     // start only when the result register can take the answer
                     if (out_free) begin
                        pop      = 1'b1;
                        node_in  = head.entry.root_index;
                        depth_in = '0;
                        acc_in   = head.entry.accumulate;
                        if (32'(head.entry.root_index) >= 32'(NODE_COUNT)) begin
                           rsp_valid_in = 1'b1;
                           pred_in      = '0;
                           leaf_in      = head.entry.root_index;
                           err_in       = 1'b1;
                        end else begin
                           node_re  = 1'b1;
                           state_in = ST_NODE;
                        end
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_NODE: begin
            priority if (node_rd_ff.term) begin
               sum_in       = acc_ff ? sum_sat : leaf_sext;
               pred_in      = acc_ff ? sum_sat : leaf_sext;
               leaf_in      = node_ff;
               err_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (32'(depth_ff) >= 32'(MAX_DEPTH) ||
                         32'(node_rd_ff.feat) >= 32'(FEATURE_COUNT)) begin
               pred_in      = '0;
               leaf_in      = node_ff;
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               feat_re  = 1'b1;
               state_in = ST_FEAT;
            end
         end
         ST_FEAT: begin
            depth_in = depth_ff + DEPTH_W'(1);
            node_in  = next_node;
            if (32'(next_node) >= 32'(NODE_COUNT)) begin
               pred_in      = '0;
               leaf_in      = next_node;
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               node_re  = 1'b1;
               node_ra  = NODE_AW'(next_node);
               state_in = ST_NODE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      node_ff  <= node_in;
      depth_ff <= depth_in;
      acc_ff   <= acc_in;
      pred_ff  <= pred_in;
      leaf_ff  <= leaf_in;
      err_ff   <= err_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {leaf_ff, pred_ff};
   assign rsp_tuser[0] = err_ff;

endmodule

`default_nettype wire

/* rtl/decision_tree_predict_unit.sv */
// Decision tree predict unit. Each write transfer is applied by the back end
// as it leaves the queue. An evaluate transfer occupies the walker until its
// result is offered: each level of its walk is one node table read then one
// feature table read.
// A four-entry queue lets requests be taken while the walker is busy.
// Reset is synchronous: clears queue, walker state, result valid and sum.
`default_nettype none

module decision_tree_predict_unit #(
   parameter int NODE_COUNT    = dtp_pkg::NODE_COUNT_DEF,
   parameter int FEATURE_COUNT = dtp_pkg::FEATURE_COUNT_DEF,
   parameter int MAX_DEPTH     = dtp_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // node_index, left_child, right_child, split_feature, split_value,
   // is_terminal, leaf_value, feature_index, feature_value, root_index,
   // accumulate, zero fill
   input  wire logic [dtp_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [dtp_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // prediction, leaf_reached
   output logic [dtp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // walk_error
   output logic [dtp_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   dtp_pkg::dtp_slot_type push;
   dtp_pkg::dtp_slot_type head;
   logic                  queue_full;
   logic                  pop;

   // Decode and filter
   dtp_front #(
      .NODE_COUNT   (NODE_COUNT),
      .FEATURE_COUNT(FEATURE_COUNT)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .queue_full(queue_full),
      .push      (push)
   );

   // Command queue
   dtp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .full (queue_full),
      .head (head)
   );

   // Tables and walk
   dtp_walker #(
      .NODE_COUNT   (NODE_COUNT),
      .FEATURE_COUNT(FEATURE_COUNT),
      .MAX_DEPTH    (MAX_DEPTH)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/dtp_checker.sv */
// Port-level checks of the decision tree predict unit, bound to the top level.
// Depends on dtp_pkg and decision_tree_predict_unit_macros.svh.
`default_nettype none

`include "decision_tree_predict_unit_macros.svh"

module dtp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   // prediction, leaf_reached
   input wire logic [dtp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // walk_error
   input wire logic [dtp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // A stalled result stays offered
   `DTP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled result keeps its payload
   `DTP_ASSERT_NXT(a_rsp_stable, rsp_tvalid && !rsp_tready,
                   $stable(rsp_tdata) && $stable(rsp_tuser))

   // A failed walk reports a zero prediction
   `DTP_ASSERT_IMP(a_err_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata[39:0] == 40'd0)

   // Nothing is offered straight after reset
   `DTP_ASSERT_IMP(a_reset_quiet, $past(reset), !rsp_tvalid)

endmodule

bind decision_tree_predict_unit dtp_checker u_dtp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
